[rtl/dsfe_pkg.sv]
// shared types, constants and leading zero count function for the double to small float encoder
package dsfe_pkg;

    localparam logic [1:0] FMT_8  = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    localparam logic [1:0] REG_FORMAT  = 2'd0;
    localparam logic [1:0] REG_MIN_MAG = 2'd1;
    localparam logic [1:0] REG_MAX_MAG = 2'd2;

    localparam logic [62:0] MAG_INF = 63'h7FF0000000000000;

    // stage one to stage two
    typedef struct packed {
        logic        flag;
        logic        sign;
        logic [1:0]  fmt;
        logic [10:0] expo;
        logic [51:0] frac;
        logic [5:0]  lz;
    } dsfe_s1_t;

    // stage two to stage three
    typedef struct packed {
        logic        flag;
        logic        sign;
        logic [1:0]  fmt;
        logic [12:0] expo;
        logic [51:0] frac;
    } dsfe_s2_t;

    // count of leading zeros in a 52-bit fraction, 52 when all zero
    function automatic logic [5:0] lzc52(input logic [51:0] f);
        logic [5:0] n;
        logic       found;
        n = 6'd52;
        found = 1'b0;
        for (int i = 51; i >= 0; i--)
        begin
            if (!found && f[i])
            begin
                n = 6'(51 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/dsfe_classify.sv]
// stage one: format check, zero and bound compares, sign and leading zero count
module dsfe_classify import dsfe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] value_bits,
    input  logic [1:0]  fmt,
    input  logic [62:0] min_mag,
    input  logic [62:0] max_mag,
    output dsfe_s1_t    s1
);
    dsfe_s1_t s1_next;
    dsfe_s1_t s1_reg;
    logic [62:0] mag;

    always_comb
    begin
        mag = value_bits[62:0];
        s1_next.flag = (fmt != FMT_8 && fmt != FMT_16 && fmt != FMT_32) ||
                       (mag == '0) || (mag < min_mag) || (mag > max_mag);
        s1_next.sign = !(!value_bits[63] && (mag <= MAG_INF));
        s1_next.fmt  = fmt;
        s1_next.expo = mag[62:52];
        s1_next.frac = mag[51:0];
        s1_next.lz   = lzc52(mag[51:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (en)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;
endmodule

[rtl/dsfe_normalize.sv]
// stage two: normalise subnormals and form the unbiased exponent
module dsfe_normalize import dsfe_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  dsfe_s1_t s1,
    output dsfe_s2_t s2
);
    dsfe_s2_t s2_next;
    dsfe_s2_t s2_reg;
    logic [52:0] shifted;

    always_comb
    begin
        shifted = {1'b0, s1.frac} << (s1.lz + 6'd1);
        s2_next.flag = s1.flag;
        s2_next.sign = s1.sign;
        s2_next.fmt  = s1.fmt;
        if (s1.expo == '0)
        begin
            // subnormal: exponent -1023 - lz
            s2_next.expo = 13'(-13'sd1023) - 13'(s1.lz);
            s2_next.frac = shifted[51:0];
        end
        else
        begin
            s2_next.expo = 13'(s1.expo) - 13'd1023;
            s2_next.frac = s1.frac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg <= '0;
        else if (en)
            s2_reg <= s2_next;
    end

    assign s2 = s2_reg;
endmodule

[rtl/dsfe_round_pack.sv]
// stage three: round half-up, bias the exponent and pack the code
module dsfe_round_pack import dsfe_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  dsfe_s2_t    s2,
    output logic [31:0] code,
    output logic        out_of_range
);
    logic [31:0] code_next, code_reg;
    logic        flag_reg;
    logic [23:0] top;
    logic [12:0] e;

    always_comb
    begin
        code_next = '0;
        top = '0;
        e = s2.expo;
        case (s2.fmt)
            FMT_8:
            begin
                top = 24'(s2.frac[51:48]) + 24'(s2.frac[47]);
                if (top[4]) begin top = '0; e = e + 13'd1; end
                code_next = 32'({s2.sign, 3'(e + 13'd3), top[3:0]});
            end
            FMT_16:
            begin
                top = 24'(s2.frac[51:42]) + 24'(s2.frac[41]);
                if (top[10]) begin top = '0; e = e + 13'd1; end
                code_next = 32'({s2.sign, 5'(e + 13'd15), top[9:0]});
            end
            FMT_32:
            begin
                top = 24'(s2.frac[51:29]) + 24'(s2.frac[28]);
                if (top[23]) begin top = '0; e = e + 13'd1; end
                code_next = {s2.sign, 8'(e + 13'd127), top[22:0]};
            end
            default: code_next = '0;
        endcase
        if (s2.flag)
            code_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
            flag_reg <= s2.flag;
        end
    end

    assign code = code_reg;
    assign out_of_range = flag_reg;
endmodule

[rtl/double_to_small_float_encoder.sv]
// top level of the double to small float encoder
// throughput: one transaction per cycle while the output is not held, through the three-stage pipeline
// a stall on a valid output holds every stage; the input stall follows it
// reset: pipeline empty, format 16-bit, both magnitude bounds zero
module double_to_small_float_encoder import dsfe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] code,
    output logic        out_of_range
);
    logic [1:0]  fmt_reg;
    logic [62:0] min_reg, max_reg;
    logic [2:0]  vld_reg;
    logic        adv;
    dsfe_s1_t    s1;
    dsfe_s2_t    s2;

    // pipeline moves whenever the output is not held
    assign adv = !(vld_reg[2] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_16;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT:  fmt_reg <= cfg_data[1:0];
                REG_MIN_MAG: min_reg <= cfg_data;
                REG_MAX_MAG: max_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    dsfe_classify u_classify (
        .clk(clk), .rst_n(rst_n), .en(adv), .value_bits(value_bits),
        .fmt(fmt_reg), .min_mag(min_reg), .max_mag(max_reg), .s1(s1)
    );

    dsfe_normalize u_normalize (
        .clk(clk), .rst_n(rst_n), .en(adv), .s1(s1), .s2(s2)
    );

    dsfe_round_pack u_round_pack (
        .clk(clk), .en(adv), .s2(s2), .code(code), .out_of_range(out_of_range)
    );
endmodule

[rtl/dsfe_checker.sv]
// port-level checks for the double to small float encoder
module dsfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] code,
    input logic        out_of_range
);
    // a flagged transaction carries a zero code
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> code == '0)
        else $error("flagged result with nonzero code");

    // input is only held back while a result waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code) && $stable(out_of_range))
        else $error("stalled result changed");
endmodule

bind double_to_small_float_encoder dsfe_checker u_dsfe_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .code(code),
    .out_of_range(out_of_range)
);

[sim/tb_double_to_small_float_encoder.sv]
// self-checking testbench for the double to small float encoder
`timescale 1ns / 1ps

module tb_double_to_small_float_encoder;
    import dsfe_pkg::*;

    typedef struct {
        logic [31:0] code;
        logic        oor;
    } enc_result_t;

    class encode_scoreboard;
        enc_result_t pending[$];
        logic [1:0]  fmt;
        logic [62:0] lo_mag;
        logic [62:0] hi_mag;
        int          mismatches;
        int          checked;

        function void reset_regs();
            fmt = FMT_16;
            lo_mag = '0;
            hi_mag = '0;
        endfunction

        function enc_result_t encode(logic [63:0] v);
            enc_result_t r;
            int          ew;
            int          fw;
            logic [62:0] mag;
            logic [52:0] m;
            longint      e;
            logic [51:0] frac;
            logic [23:0] top;
            logic [7:0]  ef;
            logic        sgn;
            r.code = '0;
            r.oor = 1'b1;
            case (fmt)
                FMT_8:  begin ew = 3; fw = 4; end
                FMT_16: begin ew = 5; fw = 10; end
                FMT_32: begin ew = 8; fw = 23; end
                default: return r;
            endcase
            mag = v[62:0];
            if (mag == 0 || mag < lo_mag || mag > hi_mag)
                return r;
            sgn = !(v[63] == 1'b0 && mag <= MAG_INF);
            if (mag[62:52] == 0)
            begin
                // subnormal: normalise to the leading one
                m = {1'b0, mag[51:0]};
                e = -1022;
                while (!m[52])
                begin
                    m = m << 1;
                    e--;
                end
                frac = m[51:0];
            end
            else
            begin
                e = longint'(mag[62:52]) - 1023;
                frac = mag[51:0];
            end
            top = 24'(frac >> (52 - fw)) + 24'((frac >> (51 - fw)) & 1);
            if ((top >> fw) != 0)
            begin
                top = 0;
                e++;
            end
            ef = 8'((e + (longint'(1) << (ew - 1)) - 1) & ((longint'(1) << ew) - 1));
            r.code = (32'(sgn) << (ew + fw)) | (32'(ef) << fw) | 32'(top);
            r.oor = 1'b0;
            return r;
        endfunction

        function void note_input(logic [63:0] v);
            pending.push_back(encode(v));
        endfunction

        function void check_result(logic [31:0] c, logic f);
            enc_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result code=%h oor=%b", c, f);
                return;
            end
            e = pending.pop_front();
            if (e.code !== c || e.oor !== f)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected code=%h oor=%b, got code=%h oor=%b",
                             e.code, e.oor, c, f);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [62:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] code;
    logic        out_of_range;

    encode_scoreboard sb;
    bit               idle_on;
    int               sent;

    double_to_small_float_encoder DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // accepted transactions on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(value_bits);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(code, out_of_range);
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [62:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_FORMAT:  sb.fmt = val[1:0];
            REG_MIN_MAG: sb.lo_mag = val;
            REG_MAX_MAG: sb.hi_mag = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [1:0] f, logic [62:0] lo, logic [62:0] hi);
        write_reg(REG_FORMAT, 63'(f));
        write_reg(REG_MIN_MAG, lo);
        write_reg(REG_MAX_MAG, hi);
    endtask

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic send_value(logic [63:0] v);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 10);
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        value_bits <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            // exponent near one so most values fit small formats
            0: v[62:52] = 11'(1023 + $signed($urandom_range(0, 20)) - 10);
            1: v[62:52] = 11'(1023 + $signed($urandom_range(0, 260)) - 130);
            2: v[62:52] = 11'($urandom_range(0, 2047));
            default: v[62:52] = 11'(1023 + $signed($urandom_range(0, 6)) - 3);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        logic [62:0] lo;
        logic [62:0] hi;
        sb = new();
        sb.reset_regs();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_FORMAT;
        cfg_data = '0;
        in_valid = 0;
        value_bits = '0;
        idle_on = 1;
        sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset bounds are zero: everything flagged
        send_value(64'h3FF0000000000000);
        send_value(64'h0);
        drain();

        directed = '{64'h0, 64'h8000000000000000, 64'h3FF0000000000000,
                     64'h4000000000000000, 64'hBFF0000000000000,
                     64'h3FF8000000000000, 64'h3FFFFFFFFFFFFFFF,
                     64'h3FF0800000000000, 64'h3FF0040000000000,
                     64'h0000000000000001, 64'h000FFFFFFFFFFFFF,
                     64'h7FF0000000000000, 64'hFFF0000000000000,
                     64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF,
                     64'h7FEFFFFFFFFFFFFF, 64'h4060000000000000,
                     64'h3F00000000000000, 64'h0010000000000000,
                     64'hC010000000000000};
        for (int f = 0; f < 4; f++)
        begin
            configure(2'(f), 63'h0, 63'h7FFFFFFFFFFFFFFF);
            foreach (directed[i]) send_value(directed[i]);
            drain();
        end
        // narrow bounds around one, tested on the edges
        configure(FMT_8, 63'h3FF0000000000000, 63'h4000000000000000);
        send_value(64'h3FEFFFFFFFFFFFFF);
        send_value(64'h3FF0000000000000);
        send_value(64'h4000000000000000);
        send_value(64'h4000000000000001);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase >= 6) idle_on = 0;
            lo = $urandom_range(0, 1) ? 63'h0 :
                 63'({$urandom, $urandom}) & 63'h3FF0FFFFFFFFFFFF;
            hi = $urandom_range(0, 3) ? 63'h7FFFFFFFFFFFFFFF : 63'({$urandom, $urandom});
            if (hi < lo) hi = 63'h7FFFFFFFFFFFFFFF;
            configure(phase == 7 ? 2'd3 : 2'($urandom_range(0, 2)), lo, hi);
            repeat (50) send_value(random_value());
            drain();
        end

        $display("ran %0d values over all formats and several bound settings", sent);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
rtl/dsfe_pkg.sv
rtl/dsfe_classify.sv
rtl/dsfe_normalize.sv
rtl/dsfe_round_pack.sv
rtl/double_to_small_float_encoder.sv
rtl/dsfe_checker.sv
sim/tb_double_to_small_float_encoder.sv
